@@ rtl/spa_pkg.sv @@
package spa_pkg;

    localparam int MaxTermsDefault = 8;
    localparam int CoefW = 32;
    localparam int ExpW = 15;
    localparam int OutExpW = 16;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_RUN         = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_EVAL = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic REG_OP_MODE = 1'b0;
    localparam logic REG_EVAL_POINT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_MUL_RD,
        ST_MUL_MUL,
        ST_MUL_EMIT,
        ST_EV_RD,
        ST_EV_SQ,
        ST_EV_SQ_W,
        ST_EV_X,
        ST_EV_X_W,
        ST_EV_TERM,
        ST_EV_TERM_W,
        ST_EV_ACC,
        ST_EV_EMIT,
        ST_EMPTY
    } state_t;

    // multiplier operand select
    typedef enum logic [1:0] {
        MSEL_PP,
        MSEL_PX,
        MSEL_CP,
        MSEL_AB
    } msel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       clr_idx;
        logic       inc_i;
        logic       inc_j;
        logic       clr_j;
        logic       p_init;
        logic       mul_go;
        msel_t      msel;
        logic       p_load;
        logic       t_load;
        logic       acc_clr;
        logic       acc_add;
        logic       bit_dec;
        logic       emit_add;
        logic       emit_mul;
        logic       emit_eval;
        logic       emit_empty;
        logic       emit_flush;
    } ctl_t;

    // datapath status
    typedef struct packed {
        logic       i_done;
        logic       j_done;
        logic       i_last;
        logic       j_last;
        logic       exp_bit;
        logic       bit_zero;
        logic       add_emits;
    } sts_t;

    // Q16.16 product with round to nearest and saturation
    function automatic logic [32:0] qround(input logic signed [63:0] p);
        logic signed [47:0] q;
        logic signed [63:0] r;
        begin
            r = p + 64'sd32768;
            q = r[63:16];
            if (q > 48'sh7FFFFFFF)
                qround = {1'b1, 32'h7FFFFFFF};
            else if (q < -48'sh80000000)
                qround = {1'b1, 32'h80000000};
            else
                qround = {1'b0, q[31:0]};
        end
    endfunction

    // saturating 32 bit add, sat flag on top
    function automatic logic [32:0] qadd(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [32:0] s;
        begin
            s = {a[31], a} + {b[31], b};
            if (s > 33'sh07FFFFFFF)
                qadd = {1'b1, 32'h7FFFFFFF};
            else if (s < -33'sh080000000)
                qadd = {1'b1, 32'h80000000};
            else
                qadd = {1'b0, s[31:0]};
        end
    endfunction

endpackage

@@ rtl/spa_ram.sv @@
module spa_ram #(
    parameter int Width = 32,
    parameter int Depth = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spa_ctrl.sv @@
module spa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          run,
    input  logic [1:0]    op_mode,
    input  spa_pkg::sts_t sts,
    output spa_pkg::ctl_t ctl,
    output logic          busy
);
    import spa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run)
                begin
                    case (op_t'(op_mode))
                        OP_ADD:  state_next = ST_ADD_RD;
                        OP_MUL:  state_next = ST_MUL_RD;
                        OP_EVAL: state_next = ST_EV_RD;
                        default: state_next = ST_EMPTY;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                if (sts.i_done && sts.j_done)
                begin
                    // flush the held term, or report an empty sum
                    if (sts.add_emits)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_EMPTY;
                end
                else
                    state_next = ST_ADD_CMP;
            end
            ST_ADD_CMP: state_next = ST_ADD_RD;
            ST_MUL_RD:
            begin
                if (sts.i_done || sts.j_done)
                    state_next = ST_EMPTY;
                else
                    state_next = ST_MUL_MUL;
            end
            ST_MUL_MUL: state_next = ST_MUL_EMIT;
            ST_MUL_EMIT:
            begin
                if (sts.i_last && sts.j_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MUL_RD;
            end
            ST_EV_RD:
            begin
                if (sts.i_done)
                    state_next = ST_EV_EMIT;
                else
                    state_next = ST_EV_SQ;
            end
            ST_EV_SQ: state_next = ST_EV_SQ_W;
            ST_EV_SQ_W:
            begin
                if (sts.exp_bit)
                    state_next = ST_EV_X;
                else if (sts.bit_zero)
                    state_next = ST_EV_TERM;
                else
                    state_next = ST_EV_SQ;
            end
            ST_EV_X: state_next = ST_EV_X_W;
            ST_EV_X_W:
            begin
                if (sts.bit_zero)
                    state_next = ST_EV_TERM;
                else
                    state_next = ST_EV_SQ;
            end
            ST_EV_TERM: state_next = ST_EV_TERM_W;
            ST_EV_TERM_W: state_next = ST_EV_ACC;
            ST_EV_ACC:
            begin
                if (sts.i_last)
                    state_next = ST_EV_EMIT;
                else
                    state_next = ST_EV_RD;
            end
            ST_EV_EMIT: state_next = ST_IDLE;
            ST_EMPTY: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        ctl.msel = MSEL_PP;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                ctl.clr_idx = 1'b1;
                ctl.acc_clr = 1'b1;
            end
            ST_ADD_RD:
                ctl.emit_flush = sts.i_done && sts.j_done && sts.add_emits;
            ST_ADD_CMP:
                ctl.emit_add = 1'b1;
            ST_MUL_MUL:
            begin
                ctl.mul_go = 1'b1;
                ctl.msel = MSEL_AB;
            end
            ST_MUL_EMIT:
            begin
                ctl.emit_mul = 1'b1;
                if (sts.j_last)
                begin
                    ctl.inc_i = 1'b1;
                    ctl.clr_j = 1'b1;
                end
                else
                    ctl.inc_j = 1'b1;
            end
            ST_EV_RD:
                ctl.p_init = 1'b1;
            ST_EV_SQ:
                ctl.mul_go = 1'b1;
            ST_EV_SQ_W:
            begin
                ctl.p_load = 1'b1;
                if (!sts.exp_bit)
                    ctl.bit_dec = 1'b1;
            end
            ST_EV_X:
            begin
                ctl.mul_go = 1'b1;
                ctl.msel = MSEL_PX;
            end
            ST_EV_X_W:
            begin
                ctl.p_load = 1'b1;
                ctl.bit_dec = 1'b1;
            end
            ST_EV_TERM:
            begin
                ctl.mul_go = 1'b1;
                ctl.msel = MSEL_CP;
            end
            ST_EV_TERM_W:
                ctl.t_load = 1'b1;
            ST_EV_ACC:
            begin
                ctl.acc_add = 1'b1;
                ctl.inc_i = 1'b1;
            end
            ST_EV_EMIT:
                ctl.emit_eval = 1'b1;
            ST_EMPTY:
                ctl.emit_empty = 1'b1;
            default:
                ctl = '0;
        endcase
    end

endmodule

@@ rtl/spa_dp.sv @@
module spa_dp #(
    parameter int MaxTerms = spa_pkg::MaxTermsDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load_first,
    input  logic                            load_second,
    input  logic                            run,
    input  logic signed [spa_pkg::CoefW-1:0] term_coef,
    input  logic [spa_pkg::ExpW-1:0]        term_exp,
    input  logic                            cfg_we,
    input  logic                            cfg_idx,
    input  logic [spa_pkg::CoefW-1:0]       cfg_data,
    output logic [1:0]                      op_mode,
    input  spa_pkg::ctl_t                   ctl,
    output spa_pkg::sts_t                   sts,
    output logic signed [spa_pkg::CoefW-1:0] out_coef,
    output logic [spa_pkg::OutExpW-1:0]     out_exp,
    output logic                            out_valid,
    output logic                            is_last,
    output logic                            is_empty,
    output logic                            saturated,
    output logic                            overflow
);
    import spa_pkg::*;

    localparam int AW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
    localparam int CW = $clog2(MaxTerms + 1);
    localparam int Depth = 1 << AW;
    localparam int EW = CoefW + ExpW;

    logic [1:0]  op_mode_reg;
    logic signed [CoefW-1:0] xpt_reg;
    logic [CW-1:0] fcnt_reg, scnt_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic drop_reg, ovf_reg;
    logic f_full, s_full;
    logic [EW-1:0] f_rd, s_rd;
    logic signed [CoefW-1:0] fc, sc;
    logic [ExpW-1:0] fe, se;
    logic [AW-1:0] f_ra, s_ra;
    logic signed [CoefW-1:0] p_reg, t_reg, acc_reg;
    logic signed [CoefW-1:0] ma, mb;
    logic signed [63:0] prod_reg;
    logic [32:0] mres, ares, sres;
    logic sat_reg;
    logic [3:0] bit_reg;
    logic i_adv, j_adv;
    logic signed [CoefW-1:0] hold_coef_reg;
    logic [OutExpW-1:0] hold_exp_reg;
    logic hold_sat_reg;
    logic signed [CoefW-1:0] add_coef;
    logic [OutExpW-1:0] add_exp;
    logic add_sat;

    assign op_mode = op_mode_reg;
    assign f_full = (fcnt_reg == CW'(MaxTerms));
    assign s_full = (scnt_reg == CW'(MaxTerms));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= '0;
            xpt_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_OP_MODE)
                op_mode_reg <= cfg_data[1:0];
            else
                xpt_reg <= cfg_data;
        end
    end

    // term stores
    spa_ram #(.Width(EW), .Depth(Depth)) u_first (
        .clk(clk), .we(load_first && !f_full), .waddr(fcnt_reg[AW-1:0]),
        .wdata({term_coef, term_exp}), .raddr(f_ra), .rdata(f_rd)
    );
    spa_ram #(.Width(EW), .Depth(Depth)) u_second (
        .clk(clk), .we(load_second && !s_full), .waddr(scnt_reg[AW-1:0]),
        .wdata({term_coef, term_exp}), .raddr(s_ra), .rdata(s_rd)
    );
    assign f_ra = i_reg[AW-1:0];
    assign s_ra = j_reg[AW-1:0];
    assign fc = f_rd[EW-1:ExpW];
    assign fe = f_rd[ExpW-1:0];
    assign sc = s_rd[EW-1:ExpW];
    assign se = s_rd[ExpW-1:0];

    // fill counts and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
            scnt_reg <= '0;
            drop_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else if (run)
        begin
            ovf_reg <= drop_reg;
            fcnt_reg <= '0;
            scnt_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (load_first)
            begin
                if (f_full)
                    drop_reg <= 1'b1;
                else
                    fcnt_reg <= fcnt_reg + 1'b1;
            end
            if (load_second)
            begin
                if (s_full)
                    drop_reg <= 1'b1;
                else
                    scnt_reg <= scnt_reg + 1'b1;
            end
        end
    end

    // the counts are cleared by run; keep a copy for the walk
    logic [CW-1:0] fn_reg, sn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_reg <= '0;
            sn_reg <= '0;
        end
        else if (run)
        begin
            fn_reg <= fcnt_reg;
            sn_reg <= scnt_reg;
        end
    end

    // merge decision
    logic take_f, take_s, both;
    always_comb
    begin
        take_f = 1'b0;
        take_s = 1'b0;
        both = 1'b0;
        if (sts.i_done)
            take_s = 1'b1;
        else if (sts.j_done)
            take_f = 1'b1;
        else if (fe != se)
        begin
            take_f = (fe > se);
            take_s = (fe < se);
        end
        else
            both = 1'b1;
    end
    assign sres = qadd(fc, sc);

    // term produced by one merge step
    always_comb
    begin
        if (both)
        begin
            add_coef = sres[31:0];
            add_sat = sres[32];
            add_exp = OutExpW'(fe);
        end
        else if (take_f)
        begin
            add_coef = fc;
            add_sat = 1'b0;
            add_exp = OutExpW'(fe);
        end
        else
        begin
            add_coef = sc;
            add_sat = 1'b0;
            add_exp = OutExpW'(se);
        end
    end

    assign sts.i_done = (i_reg >= fn_reg);
    assign sts.j_done = (j_reg >= sn_reg);
    assign sts.i_last = ((i_reg + 1'b1) >= fn_reg);
    assign sts.j_last = ((j_reg + 1'b1) >= sn_reg);
    assign sts.exp_bit = fe[bit_reg];
    assign sts.bit_zero = (bit_reg == 4'd0);

    // an add step emits unless equal exponents summed to zero
    logic add_any_reg;
    logic add_now;
    assign add_now = !(both && sres[31:0] == 32'd0);
    assign sts.add_emits = add_any_reg;

    assign i_adv = ctl.inc_i || (ctl.emit_add && (take_f || both));
    assign j_adv = ctl.inc_j || (ctl.emit_add && (take_s || both));

    // walk indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            add_any_reg <= 1'b0;
        end
        else if (ctl.clr_idx)
        begin
            i_reg <= '0;
            j_reg <= '0;
            add_any_reg <= 1'b0;
        end
        else
        begin
            if (i_adv)
                i_reg <= i_reg + 1'b1;
            if (ctl.clr_j)
                j_reg <= '0;
            else if (j_adv)
                j_reg <= j_reg + 1'b1;
            if (ctl.emit_add && add_now)
                add_any_reg <= 1'b1;
        end
    end

    // add terms are held one step so the final one can carry is_last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_coef_reg <= '0;
            hold_exp_reg <= '0;
            hold_sat_reg <= 1'b0;
        end
        else if (ctl.emit_add && add_now)
        begin
            hold_coef_reg <= add_coef;
            hold_exp_reg <= add_exp;
            hold_sat_reg <= add_sat;
        end
    end

    // shared multiplier, registered product
    always_comb
    begin
        case (ctl.msel)
            MSEL_PP: begin ma = p_reg; mb = p_reg; end
            MSEL_PX: begin ma = p_reg; mb = xpt_reg; end
            MSEL_CP: begin ma = fc; mb = p_reg; end
            default: begin ma = fc; mb = sc; end
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (ctl.mul_go)
            prod_reg <= 64'(ma) * 64'(mb);
    end
    assign mres = qround(prod_reg);
    assign ares = qadd(acc_reg, t_reg);

    // power, term and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            t_reg <= '0;
            acc_reg <= '0;
            sat_reg <= 1'b0;
            bit_reg <= '0;
        end
        else
        begin
            if (ctl.acc_clr)
            begin
                acc_reg <= '0;
                sat_reg <= 1'b0;
            end
            if (ctl.p_init)
            begin
                p_reg <= 32'sh00010000;
                bit_reg <= 4'(ExpW - 1);
            end
            if (ctl.p_load)
            begin
                p_reg <= mres[31:0];
                sat_reg <= sat_reg | mres[32];
            end
            if (ctl.bit_dec && bit_reg != 4'd0)
                bit_reg <= bit_reg - 1'b1;
            if (ctl.t_load)
            begin
                t_reg <= mres[31:0];
                sat_reg <= sat_reg | mres[32];
            end
            if (ctl.acc_add)
            begin
                acc_reg <= ares[31:0];
                sat_reg <= sat_reg | ares[32];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= (ctl.emit_add && add_now && add_any_reg) || ctl.emit_flush
                         || ctl.emit_mul || ctl.emit_eval || ctl.emit_empty;
    end

    always_ff @(posedge clk)
    begin
        overflow <= ovf_reg;
        is_empty <= ctl.emit_empty;
        out_coef <= '0;
        out_exp <= '0;
        saturated <= 1'b0;
        is_last <= 1'b1;
        if (ctl.emit_add || ctl.emit_flush)
        begin
            is_last <= ctl.emit_flush;
            out_coef <= hold_coef_reg;
            saturated <= hold_sat_reg;
            out_exp <= hold_exp_reg;
        end
        else if (ctl.emit_mul)
        begin
            is_last <= sts.i_last && sts.j_last;
            out_coef <= mres[31:0];
            saturated <= mres[32];
            out_exp <= OutExpW'(fe) + OutExpW'(se);
        end
        else if (ctl.emit_eval)
        begin
            out_coef <= acc_reg;
            saturated <= sat_reg;
        end
    end

endmodule

@@ rtl/sparse_polynomial_arith.sv @@
// channel   ports                                      handshake
// command   start busy cmd term_coef term_exp          start & !busy
// config    cfg_valid cfg_ready cfg_index cfg_data     cfg_valid & cfg_ready
// result    out_valid out_coef out_exp is_last ...     out_valid, one cycle
//
// a load never raises busy; a run keeps busy high for its whole walk
// add: each merge step reads, then compares and emits; the held last term is sent at the end
// multiply: each product is read, multiplied and emitted in turn
// evaluate: per term a squaring per exponent bit, a multiply by x per set bit and
// a coefficient multiply, on the single shared 32x32 multiplier, then an accumulate
// reset clears counts, flags, state and working registers; results cannot be stalled
module sparse_polynomial_arith #(
    parameter int MaxTerms = spa_pkg::MaxTermsDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic signed [spa_pkg::CoefW-1:0] term_coef,
    input  logic [spa_pkg::ExpW-1:0]         term_exp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [spa_pkg::CoefW-1:0]        cfg_data,
    output logic                             out_valid,
    output logic signed [spa_pkg::CoefW-1:0] out_coef,
    output logic [spa_pkg::OutExpW-1:0]      out_exp,
    output logic                             is_last,
    output logic                             is_empty,
    output logic                             saturated,
    output logic                             overflow
);
    import spa_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic [1:0] op_mode;
    logic acc, run;

    // accepted command transaction decode
    assign acc = start && !busy;
    assign run = acc && (cmd_t'(cmd) == CMD_RUN);
    assign cfg_ready = 1'b1;

    spa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .run(run), .op_mode(op_mode),
        .sts(sts), .ctl(ctl), .busy(busy)
    );

    spa_dp #(.MaxTerms(MaxTerms)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .load_first(acc && cmd_t'(cmd) == CMD_LOAD_FIRST),
        .load_second(acc && cmd_t'(cmd) == CMD_LOAD_SECOND),
        .run(run), .term_coef(term_coef), .term_exp(term_exp),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .op_mode(op_mode), .ctl(ctl), .sts(sts),
        .out_coef(out_coef), .out_exp(out_exp), .out_valid(out_valid),
        .is_last(is_last), .is_empty(is_empty), .saturated(saturated),
        .overflow(overflow)
    );

endmodule
